/* hdl/gds_pkg.sv */
// Package for the graph degree statistics core: item types, register indexes,
// control word layout and the sequencer program ROM. No dependencies.
`timescale 1ns / 1ps

package gds_pkg;

    localparam int MAX_NODES  = 64;
    localparam int NODE_IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int NODE_W     = 7;
    localparam int CFG_W      = 7;
    localparam int UPC_W      = 4;

    typedef enum logic [1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_QUERY    = 2'd1,
        OP_SUMMARY  = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    typedef enum logic {
        CFG_NODE_COUNT = 1'b0,
        CFG_MIRROR     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic              status;
        logic [NODE_W-1:0] node_degree;
        logic [NODE_W-1:0] max_degree;
        logic [NODE_W-1:0] min_degree;
        logic [NODE_W-1:0] isolated_node;
        logic              is_regular;
        logic              is_complete;
    } out_item_t;

    typedef enum logic [1:0] {
        RS_NONE,
        RS_A,
        RS_B,
        RS_SCAN
    } rd_sel_t;

    typedef enum logic [1:0] {
        WS_NONE,
        WS_A,
        WS_B
    } wr_sel_t;

    typedef enum logic [1:0] {
        SC_NONE,
        SC_START,
        SC_ACC
    } scan_op_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_BAD,
        JC_OP_QUERY,
        JC_OP_SUMMARY,
        JC_NO_MIRROR,
        JC_SCAN_MORE
    } jump_cond_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_EDGE,
        EM_QUERY,
        EM_SUMMARY,
        EM_BAD
    } emit_t;

    typedef struct packed {
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        scan_op_t   scan_op;
        jump_cond_t cond;
        logic [UPC_W-1:0] target;
        emit_t      emit;
        logic       finish;
    } ctrl_word_t;

    localparam logic [UPC_W-1:0] UPC_DISPATCH = 4'd0;
    localparam logic [UPC_W-1:0] UPC_EDGE_DONE = 4'd5;
    localparam logic [UPC_W-1:0] UPC_SUMMARY  = 4'd6;
    localparam logic [UPC_W-1:0] UPC_SCAN     = 4'd7;
    localparam logic [UPC_W-1:0] UPC_QUERY    = 4'd9;
    localparam logic [UPC_W-1:0] UPC_BAD      = 4'd10;

    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
        ctrl_word_t cw;
        cw = '{rd_sel: RS_NONE, wr_sel: WS_NONE, scan_op: SC_NONE, cond: JC_NEVER,
               target: UPC_DISPATCH, emit: EM_NONE, finish: 1'b0};
        case (upc)
            4'd0:
            begin
                cw.rd_sel = RS_A;
                cw.cond   = JC_BAD;
                cw.target = UPC_BAD;
            end
            4'd1:
            begin
                cw.cond   = JC_OP_QUERY;
                cw.target = UPC_QUERY;
            end
            4'd2:
            begin
                cw.cond   = JC_OP_SUMMARY;
                cw.target = UPC_SUMMARY;
            end
            4'd3:
            begin
                cw.wr_sel = WS_A;
                cw.rd_sel = RS_B;
                cw.cond   = JC_NO_MIRROR;
                cw.target = UPC_EDGE_DONE;
            end
            4'd4:
            begin
                cw.wr_sel = WS_B;
            end
            4'd5:
            begin
                cw.emit   = EM_EDGE;
                cw.finish = 1'b1;
            end
            4'd6:
            begin
                cw.rd_sel  = RS_SCAN;
                cw.scan_op = SC_START;
            end
            4'd7:
            begin
                cw.rd_sel  = RS_SCAN;
                cw.scan_op = SC_ACC;
                cw.cond    = JC_SCAN_MORE;
                cw.target  = UPC_SCAN;
            end
            4'd8:
            begin
                cw.emit   = EM_SUMMARY;
                cw.finish = 1'b1;
            end
            4'd9:
            begin
                cw.emit   = EM_QUERY;
                cw.finish = 1'b1;
            end
            4'd10:
            begin
                cw.emit   = EM_BAD;
                cw.finish = 1'b1;
            end
            default:
            begin
                cw.emit   = EM_BAD;
                cw.finish = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

/* hdl/graph_degree_statistics_core.sv */
// Graph degree statistics core: adjacency row memory, degree memory and a
// microcoded sequencer that runs the program held in gds_pkg.
`timescale 1ns / 1ps

// Usage
// An item is taken when start is high and busy is low. It carries an opcode
// (add edge, query degree, summary) and two 1-based node numbers. Exactly one
// result item follows on result, marked by done for a single cycle, in
// the same cycle that busy falls; the receiver cannot stall, so it must
// take it then. A rejected item jumps from dispatch straight to its error
// result; an edge insert writes the row of node_a and, with mirroring,
// then that of node_b; a summary walks the degree memory read port one node
// per cycle over the first node_count nodes. An edge insert is a read-modify-write
// of one adjacency row per direction through the same port.
// Configuration writes (node_count, mirror_edges) are taken on any cycle
// that cfg_wr_en is high and should only be issued while the core is idle.
// Reset clears every row valid bit at once, so the matrix and all degrees
// read as zero right after reset; node_count returns to 64 and mirroring on.
module graph_degree_statistics_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gds_pkg::in_item_t             in_item,
    output logic                          done,
    output gds_pkg::out_item_t            result,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [gds_pkg::CFG_W-1:0]     cfg_data
);

    import gds_pkg::*;

    logic [NODE_W-1:0]     node_count_reg;
    logic                  mirror_reg;
    logic                  busy_reg;
    logic [UPC_W-1:0]      upc_reg, upc_next;
    logic [1:0]            op_reg;
    logic [NODE_W-1:0]     a_reg, b_reg;
    logic                  done_reg;
    out_item_t             result_reg, result_next;

    logic [MAX_NODES-1:0]  row_mem [MAX_NODES];
    logic [CNT_W-1:0]      deg_mem [MAX_NODES];
    logic [MAX_NODES-1:0]  row_vld_reg;
    logic [MAX_NODES-1:0]  row_rd_reg;
    logic [CNT_W-1:0]      deg_rd_reg;
    logic                  vld_rd_reg;

    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      mx_reg, mn_reg, d0_reg;
    logic [CNT_W-1:0]      iso_reg;
    logic                  regular_reg, complete_reg;

    ctrl_word_t            cw;
    logic                  accept;
    logic [CNT_W-1:0]      n_eff, n_m1;
    logic [CNT_W-1:0]      a_ext, b_ext;
    logic [NODE_W-1:0]     a_m1, b_m1;
    logic [NODE_IDX_W-1:0] a_idx, b_idx, rd_addr, wr_row;
    logic [NODE_IDX_W-1:0] wr_col;
    logic [MAX_NODES-1:0]  row_eff;
    logic [CNT_W-1:0]      deg_eff;
    logic                  a_bad, b_bad, item_bad, bit_new, wr_fire, take_jump;

    assign accept = start && !busy_reg;
    assign cw     = ucode_rom(upc_reg);

    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (CNT_W'(node_count_reg) > CNT_W'(MAX_NODES))
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = CNT_W'(node_count_reg);
    end

    assign n_m1  = n_eff - CNT_W'(1);
    assign a_ext = CNT_W'(a_reg);
    assign b_ext = CNT_W'(b_reg);
    assign a_m1  = a_reg - NODE_W'(1);
    assign b_m1  = b_reg - NODE_W'(1);
    assign a_idx = a_m1[NODE_IDX_W-1:0];
    assign b_idx = b_m1[NODE_IDX_W-1:0];
    assign a_bad = (a_reg == '0) || (a_ext > n_eff);
    assign b_bad = (b_reg == '0) || (b_ext > n_eff);

    always_comb
    begin
        case (op_reg)
            OP_ADD_EDGE: item_bad = a_bad || b_bad || (a_reg == b_reg);
            OP_QUERY:    item_bad = a_bad;
            OP_SUMMARY:  item_bad = 1'b0;
            default:     item_bad = 1'b1;
        endcase
    end

    always_comb
    begin
        case (cw.rd_sel)
            RS_A:    rd_addr = a_idx;
            RS_B:    rd_addr = b_idx;
            RS_SCAN: rd_addr = (cw.scan_op == SC_START) ? '0 : idx_reg[NODE_IDX_W-1:0];
            default: rd_addr = a_idx;
        endcase
    end

    always_comb
    begin
        case (cw.wr_sel)
            WS_A:
            begin
                wr_row = a_idx;
                wr_col = b_idx;
            end
            WS_B:
            begin
                wr_row = b_idx;
                wr_col = a_idx;
            end
            default:
            begin
                wr_row = a_idx;
                wr_col = b_idx;
            end
        endcase
    end

    assign row_eff = vld_rd_reg ? row_rd_reg : '0;
    assign deg_eff = vld_rd_reg ? deg_rd_reg : '0;
    assign bit_new = !row_eff[wr_col];
    assign wr_fire = busy_reg && (cw.wr_sel != WS_NONE) && bit_new;

    always_ff @(posedge clk)
    begin
        if (busy_reg && (cw.rd_sel != RS_NONE))
        begin
            row_rd_reg <= row_mem[rd_addr];
            deg_rd_reg <= deg_mem[rd_addr];
        end
        if (wr_fire)
        begin
            row_mem[wr_row] <= row_eff | (MAX_NODES'(1) << wr_col);
            deg_mem[wr_row] <= deg_eff + CNT_W'(1);
        end
    end

    always_comb
    begin
        case (cw.cond)
            JC_BAD:        take_jump = item_bad;
            JC_OP_QUERY:   take_jump = (op_reg == OP_QUERY);
            JC_OP_SUMMARY: take_jump = (op_reg == OP_SUMMARY);
            JC_NO_MIRROR:  take_jump = !mirror_reg;
            JC_SCAN_MORE:  take_jump = (idx_reg < n_eff);
            default:       take_jump = 1'b0;
        endcase
        upc_next = take_jump ? cw.target : upc_reg + UPC_W'(1);
    end

    always_comb
    begin
        result_next = '0;
        case (cw.emit)
            EM_QUERY:   result_next.node_degree = NODE_W'(deg_eff);
            EM_SUMMARY:
            begin
                result_next.max_degree    = NODE_W'(mx_reg);
                result_next.min_degree    = NODE_W'(mn_reg);
                result_next.isolated_node = NODE_W'(iso_reg);
                result_next.is_regular    = regular_reg;
                result_next.is_complete   = complete_reg;
            end
            EM_BAD:     result_next.status = 1'b1;
            default:    result_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && (cw.scan_op == SC_START))
            idx_reg <= CNT_W'(1);
        else if (busy_reg && (cw.scan_op == SC_ACC))
        begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (idx_reg == CNT_W'(1))
            begin
                mx_reg       <= deg_eff;
                mn_reg       <= deg_eff;
                d0_reg       <= deg_eff;
                iso_reg      <= (deg_eff == '0) ? CNT_W'(1) : '0;
                regular_reg  <= 1'b1;
                complete_reg <= (deg_eff == n_m1);
            end
            else
            begin
                if (deg_eff > mx_reg)
                    mx_reg <= deg_eff;
                if (deg_eff < mn_reg)
                    mn_reg <= deg_eff;
                if ((deg_eff == '0) && (iso_reg == '0))
                    iso_reg <= idx_reg;
                if (deg_eff != d0_reg)
                    regular_reg <= 1'b0;
                if (deg_eff != n_m1)
                    complete_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_W'(64);
            mirror_reg     <= 1'b1;
            busy_reg       <= 1'b0;
            upc_reg        <= UPC_DISPATCH;
            done_reg       <= 1'b0;
            row_vld_reg    <= '0;
            vld_rd_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT: node_count_reg <= cfg_data[NODE_W-1:0];
                    CFG_MIRROR:     mirror_reg     <= cfg_data[0];
                    default:        mirror_reg     <= mirror_reg;
                endcase
            end
            done_reg <= 1'b0;
            if (accept)
            begin
                busy_reg <= 1'b1;
                upc_reg  <= UPC_DISPATCH;
            end
            else if (busy_reg)
            begin
                upc_reg <= upc_next;
                if (cw.finish)
                    busy_reg <= 1'b0;
                if (cw.emit != EM_NONE)
                    done_reg <= 1'b1;
            end
            if (busy_reg && (cw.rd_sel != RS_NONE))
                vld_rd_reg <= row_vld_reg[rd_addr];
            if (wr_fire)
                row_vld_reg[wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= in_item.opcode;
            a_reg  <= in_item.node_a;
            b_reg  <= in_item.node_b;
        end
        if (busy_reg && (cw.emit != EM_NONE))
            result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while the sequencer is still running");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && (upc_reg == UPC_DISPATCH)))
        else $error("accepted item did not start the program");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (cw.scan_op == SC_ACC)) |-> (idx_reg <= n_eff))
        else $error("summary scan ran past the node count");

    a_write_checked: assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire |-> (!item_bad && (op_reg == OP_ADD_EDGE)))
        else $error("adjacency write on an item that is not a valid edge");
`endif

endmodule
